/* sv/zvrc_pkg.sv */
// Shared types and constants for the zone valve relay controller.
`timescale 1ns / 1ps

package zvrc_pkg;

  // Field widths fixed by the block definition
  localparam int ZONE_W     = 15;
  localparam int ZONE_IDX_W = 4;
  localparam int RELAY_W    = 16;
  localparam int PULSE_W    = 22;
  localparam int CHANGE_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LIST_LEN   = 16;
  localparam int OP_W       = 2;

  // Ticks with no change before a save is requested
  localparam logic [CHANGE_W-1:0] SAVE_DELAY = CHANGE_W'(30000);

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_CMD     = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ZONES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COIL_ON_OPEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LIST = 3'd4;

  // Decoded configuration seen by the sequencer
  typedef struct packed {
    logic [ZONE_IDX_W-1:0]    zones_en;      // num_zones after clamping
    logic [ZONE_W-1:0]        en_mask;       // one bit per enabled zone
    logic [PULSE_W-1:0]       pulse_ticks;
    logic                     coil_on_open;
    logic [ZONE_IDX_W-1:0]    default_count;
    logic [CFG_DATA_W-1:0]    default_list;
  } cfg_t;

endpackage

/* sv/zone_valve_relay_controller_unit.sv */
// Top level of the zone valve relay controller: item sequencer and result register.
`timescale 1ns / 1ps

// Zone valve relay controller.
// Input channel (in_valid/in_stall): one item per transfer, an operation code with
// the zone number, turn-on flag and saved zone bits. Output channel
// (out_valid/out_stall): exactly one result per item, showing the state after it.
// cfg_we/cfg_index/cfg_data write one register per cycle; the user must write
// only while the block is idle, which the block itself does not enforce.
// Ticks, out-of-range commands and no-ops go straight to the done step; the
// result then loads into the output register once that is free. An in-range
// command or a restore runs the apply sequence: count open zones, walk the
// default list one entry at a time through the single compare/increment unit,
// write relays, then the result. in_stall is high while an item is
// being worked on, and while a finished result waits for a full output register;
// a result waiting for the receiver does not block the next transfer. When the
// receiver stalls, the output holds steady. Reset (rst_n low, synchronous)
// closes all zones, clears relays and timers and loads register defaults.
module zone_valve_relay_controller_unit #(
  parameter int MAX_ZONE_COUNT = 15,
  parameter int MASTER_BIT     = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [zvrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zvrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [zvrc_pkg::OP_W-1:0]         in_operation,
  input  logic [zvrc_pkg::ZONE_IDX_W-1:0]   in_zone_number,
  input  logic                              in_turn_on,
  input  logic [zvrc_pkg::ZONE_W-1:0]       in_saved_bits,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [zvrc_pkg::RELAY_W-1:0]      out_relay_image,
  output logic [zvrc_pkg::ZONE_W-1:0]       out_zone_open_bits,
  output logic                              out_pulse_active,
  output logic                              out_command_accepted,
  output logic                              out_save_request
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_RELAY = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  zvrc_pkg::cfg_t cfg;

  logic [2:0]                       state_r, state_nxt;
  logic [zvrc_pkg::ZONE_IDX_W-1:0]  walk_idx_r, walk_idx_nxt;
  logic [zvrc_pkg::ZONE_IDX_W-1:0]  opened_r, opened_nxt;
  logic [zvrc_pkg::ZONE_W-1:0]      zone_open_r, zone_open_nxt;
  logic [zvrc_pkg::RELAY_W-1:0]     relay_r, relay_nxt;
  logic                             pulse_running_r, pulse_running_nxt;
  logic [zvrc_pkg::PULSE_W-1:0]     pulse_elapsed_r, pulse_elapsed_nxt;
  logic                             change_pending_r, change_pending_nxt;
  logic [zvrc_pkg::CHANGE_W-1:0]    change_elapsed_r, change_elapsed_nxt;
  logic                             accepted_r, accepted_nxt;
  logic                             save_r, save_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_load;

  logic                             in_xfer;
  logic [zvrc_pkg::ZONE_IDX_W-1:0]  zidx;
  logic [zvrc_pkg::ZONE_IDX_W-1:0]  entry;
  logic [zvrc_pkg::ZONE_IDX_W-1:0]  popcnt;
  logic [zvrc_pkg::PULSE_W-1:0]     pulse_inc;
  logic [zvrc_pkg::CHANGE_W-1:0]    change_inc;
  logic [zvrc_pkg::ZONE_W-1:0]      open_en;

  zvrc_cfg #(
    .MAX_ZONE_COUNT (MAX_ZONE_COUNT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Datapath helpers: zone index, list entry, saturating counters, open count
  always_comb begin
    zidx       = in_zone_number - zvrc_pkg::ZONE_IDX_W'(1);
    entry      = cfg.default_list[{walk_idx_r, 2'b00} +: zvrc_pkg::ZONE_IDX_W];
    pulse_inc  = (&pulse_elapsed_r) ? pulse_elapsed_r
                                    : pulse_elapsed_r + zvrc_pkg::PULSE_W'(1);
    change_inc = (&change_elapsed_r) ? change_elapsed_r
                                     : change_elapsed_r + zvrc_pkg::CHANGE_W'(1);
    open_en    = zone_open_r & cfg.en_mask;
    popcnt     = '0;
    for (int i = 0; i < zvrc_pkg::ZONE_W; i++) begin
      popcnt = popcnt + zvrc_pkg::ZONE_IDX_W'(open_en[i]);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt          = state_r;
    walk_idx_nxt       = walk_idx_r;
    opened_nxt         = opened_r;
    zone_open_nxt      = zone_open_r;
    relay_nxt          = relay_r;
    pulse_running_nxt  = pulse_running_r;
    pulse_elapsed_nxt  = pulse_elapsed_r;
    change_pending_nxt = change_pending_r;
    change_elapsed_nxt = change_elapsed_r;
    accepted_nxt       = accepted_r;
    save_nxt           = save_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          accepted_nxt = 1'b0;
          save_nxt     = 1'b0;
          state_nxt    = S_DONE;
          case (in_operation)
            zvrc_pkg::OP_TICK: begin
              if (pulse_running_r) begin
                pulse_elapsed_nxt = pulse_inc;
                if (pulse_inc >= cfg.pulse_ticks) begin
                  relay_nxt[MASTER_BIT] = 1'b0;
                  relay_nxt = relay_nxt & ~zvrc_pkg::RELAY_W'(cfg.en_mask);
                  pulse_running_nxt = 1'b0;
                end
              end
              change_elapsed_nxt = change_inc;
              if (change_pending_r && (change_inc >= zvrc_pkg::SAVE_DELAY)) begin
                save_nxt           = 1'b1;
                change_pending_nxt = 1'b0;
              end
            end
            zvrc_pkg::OP_CMD: begin
              if ((in_zone_number != '0) && (in_zone_number <= cfg.zones_en)) begin
                zone_open_nxt[zidx] = in_turn_on;
                change_pending_nxt  = 1'b1;
                change_elapsed_nxt  = '0;
                accepted_nxt        = 1'b1;
                state_nxt           = S_COUNT;
              end
            end
            zvrc_pkg::OP_RESTORE: begin
              relay_nxt          = '0;
              zone_open_nxt      = (zone_open_r & ~cfg.en_mask) | (in_saved_bits & cfg.en_mask);
              change_pending_nxt = 1'b1;
              change_elapsed_nxt = '0;
              state_nxt          = S_COUNT;
            end
            default: ;  // no-op: result only
          endcase
        end
      end
      // count open enabled zones
      S_COUNT: begin
        opened_nxt   = popcnt;
        walk_idx_nxt = '0;
        state_nxt    = S_WALK;
      end
      // one default list entry per cycle
      S_WALK: begin
        if ((walk_idx_r < cfg.default_count) && (opened_r < cfg.default_count)) begin
          if ((entry < cfg.zones_en) && !zone_open_r[entry]) begin
            zone_open_nxt[entry] = 1'b1;
            opened_nxt           = opened_r + zvrc_pkg::ZONE_IDX_W'(1);
          end
          walk_idx_nxt = walk_idx_r + zvrc_pkg::ZONE_IDX_W'(1);
        end else begin
          state_nxt = S_RELAY;
        end
      end
      // relay image: open XNOR coil polarity, master last
      S_RELAY: begin
        for (int i = 0; i < zvrc_pkg::ZONE_W; i++) begin
          if (cfg.en_mask[i]) begin
            relay_nxt[i] = ~(zone_open_r[i] ^ cfg.coil_on_open);
          end
        end
        relay_nxt[MASTER_BIT] = 1'b1;
        pulse_running_nxt     = 1'b1;
        pulse_elapsed_nxt     = '0;
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      walk_idx_r       <= '0;
      opened_r         <= '0;
      zone_open_r      <= '0;
      relay_r          <= '0;
      pulse_running_r  <= 1'b0;
      pulse_elapsed_r  <= '0;
      change_pending_r <= 1'b0;
      change_elapsed_r <= '0;
      accepted_r       <= 1'b0;
      save_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      walk_idx_r       <= walk_idx_nxt;
      opened_r         <= opened_nxt;
      zone_open_r      <= zone_open_nxt;
      relay_r          <= relay_nxt;
      pulse_running_r  <= pulse_running_nxt;
      pulse_elapsed_r  <= pulse_elapsed_nxt;
      change_pending_r <= change_pending_nxt;
      change_elapsed_r <= change_elapsed_nxt;
      accepted_r       <= accepted_nxt;
      save_r           <= save_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload, loaded into the output register when a finished result moves in
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_relay_image      <= relay_r;
      out_zone_open_bits   <= zone_open_r;
      out_pulse_active     <= pulse_running_r;
      out_command_accepted <= accepted_r;
      out_save_request     <= save_r;
    end
  end

  assign out_valid = out_valid_r;

  // Master relay bit tracks the pulse whenever no item is in flight
  a_master_tracks_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (relay_r[MASTER_BIT] == pulse_running_r))
    else $error("master relay bit out of step with pulse timer");

  // Relay write step always starts the pulse
  a_relay_starts_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELAY) |=> (pulse_running_r && relay_r[MASTER_BIT] &&
                              (pulse_elapsed_r == '0)))
    else $error("apply step did not start the master pulse");

  // Default list walk never runs past the entry count
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (walk_idx_r <= cfg.default_count))
    else $error("default list walk overran its count");

  // An accepted command result always shows the master relay energized
  a_cmd_result_master: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_command_accepted |-> out_relay_image[MASTER_BIT])
    else $error("accepted command result without master relay");

endmodule

/* sv/zvrc_cfg.sv */
// Configuration registers with zone count clamp and enable mask decode.
`timescale 1ns / 1ps

module zvrc_cfg #(
  parameter int MAX_ZONE_COUNT = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [zvrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zvrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output zvrc_pkg::cfg_t                    cfg
);

  localparam logic [zvrc_pkg::ZONE_IDX_W-1:0] MAX_Z = zvrc_pkg::ZONE_IDX_W'(MAX_ZONE_COUNT);

  logic [zvrc_pkg::ZONE_IDX_W-1:0] num_zones_r;
  logic [zvrc_pkg::PULSE_W-1:0]    pulse_ticks_r;
  logic                            coil_on_open_r;
  logic [zvrc_pkg::ZONE_IDX_W-1:0] default_count_r;
  logic [zvrc_pkg::CFG_DATA_W-1:0] default_list_r;
  logic [zvrc_pkg::ZONE_IDX_W-1:0] zones_en;
  logic [zvrc_pkg::ZONE_W-1:0]     en_mask;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_zones_r     <= zvrc_pkg::ZONE_IDX_W'(8);
      pulse_ticks_r   <= zvrc_pkg::PULSE_W'(30000);
      coil_on_open_r  <= 1'b0;
      default_count_r <= '0;
      default_list_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        zvrc_pkg::REG_NUM_ZONES:    num_zones_r     <= cfg_data[zvrc_pkg::ZONE_IDX_W-1:0];
        zvrc_pkg::REG_PULSE_TICKS:  pulse_ticks_r   <= cfg_data[zvrc_pkg::PULSE_W-1:0];
        zvrc_pkg::REG_COIL_ON_OPEN: coil_on_open_r  <= cfg_data[0];
        zvrc_pkg::REG_DEFAULT_CNT:  default_count_r <= cfg_data[zvrc_pkg::ZONE_IDX_W-1:0];
        zvrc_pkg::REG_DEFAULT_LIST: default_list_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp and enable mask
  always_comb begin
    zones_en = (num_zones_r > MAX_Z) ? MAX_Z : num_zones_r;
    for (int i = 0; i < zvrc_pkg::ZONE_W; i++) begin
      en_mask[i] = (zvrc_pkg::ZONE_IDX_W'(i) < zones_en);
    end
  end

  assign cfg.zones_en      = zones_en;
  assign cfg.en_mask       = en_mask;
  assign cfg.pulse_ticks   = pulse_ticks_r;
  assign cfg.coil_on_open  = coil_on_open_r;
  assign cfg.default_count = default_count_r;
  assign cfg.default_list  = default_list_r;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the zone valve relay controller unit.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int ZONE_LIMIT     = 15;
  localparam int MASTER         = 15;
  localparam logic [zvrc_pkg::PULSE_W-1:0]  PULSE_SAT  = '1;
  localparam logic [zvrc_pkg::CHANGE_W-1:0] CHANGE_SAT = '1;

  typedef struct packed {
    logic [zvrc_pkg::OP_W-1:0]       op;
    logic [zvrc_pkg::ZONE_IDX_W-1:0] zone;
    logic                            turn_on;
    logic [zvrc_pkg::ZONE_W-1:0]     saved;
  } valve_item_t;

  typedef struct packed {
    logic [zvrc_pkg::RELAY_W-1:0] relay;
    logic [zvrc_pkg::ZONE_W-1:0]  open;
    logic                         pulse;
    logic                         accepted;
    logic                         save;
  } relay_state_t;

  // DUT signals
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [zvrc_pkg::CFG_IDX_W-1:0]  cfg_index = zvrc_pkg::REG_NUM_ZONES;
  logic [zvrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [zvrc_pkg::OP_W-1:0]       in_operation = zvrc_pkg::OP_TICK;
  logic [zvrc_pkg::ZONE_IDX_W-1:0] in_zone_number = '0;
  logic                            in_turn_on = 1'b0;
  logic [zvrc_pkg::ZONE_W-1:0]     in_saved_bits = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [zvrc_pkg::RELAY_W-1:0]    out_relay_image;
  logic [zvrc_pkg::ZONE_W-1:0]     out_zone_open_bits;
  logic                            out_pulse_active;
  logic                            out_command_accepted;
  logic                            out_save_request;

  // Predictor copy of the registers (reset values)
  logic [zvrc_pkg::ZONE_IDX_W-1:0] cfg_zones = 4'd8;
  logic [zvrc_pkg::PULSE_W-1:0]    cfg_pulse = zvrc_pkg::PULSE_W'(30000);
  logic                            cfg_coil = 1'b0;
  logic [zvrc_pkg::ZONE_IDX_W-1:0] cfg_dflt_cnt = '0;
  logic [zvrc_pkg::CFG_DATA_W-1:0] cfg_dflt_list = '0;

  // Predictor copy of the block state
  logic [zvrc_pkg::ZONE_W-1:0]   st_open = '0;
  logic [zvrc_pkg::RELAY_W-1:0]  st_relay = '0;
  logic                          st_pulse_on = 1'b0;
  logic [zvrc_pkg::PULSE_W-1:0]  st_pulse_cnt = '0;
  logic                          st_save_pend = 1'b0;
  logic [zvrc_pkg::CHANGE_W-1:0] st_quiet_cnt = '0;

  // Bench bookkeeping
  valve_item_t  pending_valve_items[$];
  relay_state_t expected_relay_states[$];
  valve_item_t  sent_item;
  relay_state_t want;
  int           results_owed = 0;
  int           fail_cnt = 0;
  int           in_hold = 0;
  int           out_hold = 0;
  int           quiet_cycles = 0;
  bit           idle_on = 1'b1;

  zone_valve_relay_controller_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_zone_number       (in_zone_number),
    .in_turn_on           (in_turn_on),
    .in_saved_bits        (in_saved_bits),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_relay_image      (out_relay_image),
    .out_zone_open_bits   (out_zone_open_bits),
    .out_pulse_active     (out_pulse_active),
    .out_command_accepted (out_command_accepted),
    .out_save_request     (out_save_request)
  );

  always #5 clk = ~clk;

  // Apply step: force defaults open, drive zone relays, start the master pulse
  function automatic void drive_zone_relays(int nz);
    int opened;
    logic [zvrc_pkg::ZONE_IDX_W-1:0] z;
    opened = 0;
    for (int i = 0; i < nz; i++) if (st_open[i]) opened++;
    for (int i = 0; i < int'(cfg_dflt_cnt) && i < zvrc_pkg::LIST_LEN &&
         opened < int'(cfg_dflt_cnt); i++) begin
      z = cfg_dflt_list[4*i +: 4];
      if (int'(z) < nz) begin
        if (!st_open[z]) begin
          st_open[z] = 1'b1;
          opened++;
        end
      end
    end
    for (int i = 0; i < nz; i++) st_relay[i] = st_open[i] ? cfg_coil : !cfg_coil;
    st_relay[MASTER] = 1'b1;
    st_pulse_on = 1'b1;
    st_pulse_cnt = '0;
  endfunction

  // Advance the predicted state by one item and return the state seen after it
  function automatic relay_state_t next_relay_state(valve_item_t it);
    relay_state_t r;
    int nz;
    r = '0;
    nz = (int'(cfg_zones) > ZONE_LIMIT) ? ZONE_LIMIT : int'(cfg_zones);
    case (it.op)
      zvrc_pkg::OP_TICK: begin
        if (st_pulse_on) begin
          if (st_pulse_cnt != PULSE_SAT) st_pulse_cnt++;
          if (st_pulse_cnt >= cfg_pulse) begin
            // master clear first, then the enabled zone relays
            st_relay[MASTER] = 1'b0;
            for (int i = 0; i < nz; i++) st_relay[i] = 1'b0;
            st_pulse_on = 1'b0;
          end
        end
        if (st_quiet_cnt != CHANGE_SAT) st_quiet_cnt++;
        if (st_save_pend && st_quiet_cnt >= zvrc_pkg::SAVE_DELAY) begin
          r.save = 1'b1;
          st_save_pend = 1'b0;
        end
      end
      zvrc_pkg::OP_CMD: begin
        if (it.zone >= 1 && int'(it.zone) <= nz) begin
          st_open[int'(it.zone) - 1] = it.turn_on;
          st_save_pend = 1'b1;
          st_quiet_cnt = '0;
          r.accepted = 1'b1;
          drive_zone_relays(nz);
        end
      end
      zvrc_pkg::OP_RESTORE: begin
        st_relay = '0;
        for (int i = 0; i < nz; i++) st_open[i] = it.saved[i];
        st_save_pend = 1'b1;
        st_quiet_cnt = '0;
        drive_zone_relays(nz);
      end
      default: ;
    endcase
    r.relay = st_relay;
    r.open  = st_open;
    r.pulse = st_pulse_on;
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      fail_cnt++;
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
    end
  endtask

  // Input driver: predict on each transfer, then offer the next queued item
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_relay_states.push_back(next_relay_state(sent_item));
      if (!in_valid || !in_stall) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (pending_valve_items.size() > 0) begin
          sent_item = pending_valve_items.pop_front();
          in_operation   <= sent_item.op;
          in_zone_number <= sent_item.zone;
          in_turn_on     <= sent_item.turn_on;
          in_saved_bits  <= sent_item.saved;
          in_valid       <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) in_hold = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_owed--;
        if (expected_relay_states.size() == 0) begin
          fail_cnt++;
          $error("result transfer with nothing expected");
        end else begin
          want = expected_relay_states.pop_front();
          check_field("relay_image", 32'(want.relay), 32'(out_relay_image));
          check_field("zone_open_bits", 32'(want.open), 32'(out_zone_open_bits));
          check_field("pulse_active", 32'(want.pulse), 32'(out_pulse_active));
          check_field("command_accepted", 32'(want.accepted), 32'(out_command_accepted));
          check_field("save_request", 32'(want.save), 32'(out_save_request));
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 11) == 0) out_hold = $urandom_range(1, 13);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_item(logic [zvrc_pkg::OP_W-1:0] op,
                            logic [zvrc_pkg::ZONE_IDX_W-1:0] zone, logic on,
                            logic [zvrc_pkg::ZONE_W-1:0] saved);
    valve_item_t it;
    it.op = op;
    it.zone = zone;
    it.turn_on = on;
    it.saved = saved;
    pending_valve_items.push_back(it);
    results_owed++;
  endtask

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++)
      queue_item(zvrc_pkg::OP_TICK, zvrc_pkg::ZONE_IDX_W'($urandom), 1'($urandom),
                 zvrc_pkg::ZONE_W'($urandom));
  endtask

  // Wait until every queued item has produced its result, then let the block go idle
  task automatic settle();
    while (results_owed > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [zvrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [zvrc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic program_valves(logic [zvrc_pkg::ZONE_IDX_W-1:0] zones,
                                logic [zvrc_pkg::PULSE_W-1:0] pulse,
                                logic coil, logic [zvrc_pkg::ZONE_IDX_W-1:0] dcnt,
                                logic [zvrc_pkg::CFG_DATA_W-1:0] dlist);
    write_reg(zvrc_pkg::REG_NUM_ZONES, zvrc_pkg::CFG_DATA_W'(zones));
    write_reg(zvrc_pkg::REG_PULSE_TICKS, zvrc_pkg::CFG_DATA_W'(pulse));
    write_reg(zvrc_pkg::REG_COIL_ON_OPEN, zvrc_pkg::CFG_DATA_W'(coil));
    write_reg(zvrc_pkg::REG_DEFAULT_CNT, zvrc_pkg::CFG_DATA_W'(dcnt));
    write_reg(zvrc_pkg::REG_DEFAULT_LIST, dlist);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_zones = zones;
    cfg_pulse = pulse;
    cfg_coil = coil;
    cfg_dflt_cnt = dcnt;
    cfg_dflt_list = dlist;
  endtask

  // Random mix: mostly in-range commands and ticks, plus restores, no-ops and tick bursts
  task automatic random_phase(int count);
    int nz;
    int pick;
    logic [zvrc_pkg::ZONE_IDX_W-1:0] zone;
    nz = int'(cfg_zones);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_ticks(1);
      end else if (pick < 70) begin
        if (nz > 0 && pick < 64) zone = zvrc_pkg::ZONE_IDX_W'($urandom_range(1, nz));
        else zone = zvrc_pkg::ZONE_IDX_W'($urandom);
        queue_item(zvrc_pkg::OP_CMD, zone, 1'($urandom), zvrc_pkg::ZONE_W'($urandom));
      end else if (pick < 84) begin
        queue_item(zvrc_pkg::OP_RESTORE, zvrc_pkg::ZONE_IDX_W'($urandom), 1'($urandom),
                   zvrc_pkg::ZONE_W'($urandom));
      end else if (pick < 90) begin
        queue_item(zvrc_pkg::OP_NOP, zvrc_pkg::ZONE_IDX_W'($urandom), 1'($urandom),
                   zvrc_pkg::ZONE_W'($urandom));
      end else begin
        queue_ticks($urandom_range(2, 20));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, range edges of commands, restores, no-op
    queue_item(zvrc_pkg::OP_TICK, 4'd0, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_NOP, 4'd15, 1'b1, 15'h7FFF);
    queue_item(zvrc_pkg::OP_CMD, 4'd0, 1'b1, 15'h0000);
    queue_item(zvrc_pkg::OP_CMD, 4'd9, 1'b1, 15'h0000);
    queue_item(zvrc_pkg::OP_CMD, 4'd15, 1'b0, 15'h7FFF);
    queue_item(zvrc_pkg::OP_CMD, 4'd1, 1'b1, 15'h0000);
    queue_item(zvrc_pkg::OP_CMD, 4'd8, 1'b1, 15'h0000);
    queue_item(zvrc_pkg::OP_CMD, 4'd8, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_RESTORE, 4'd0, 1'b0, 15'h7FFF);
    queue_item(zvrc_pkg::OP_RESTORE, 4'd15, 1'b1, 15'h0000);
    queue_item(zvrc_pkg::OP_RESTORE, 4'd0, 1'b0, 15'h2AAA);
    queue_item(zvrc_pkg::OP_TICK, 4'd15, 1'b1, 15'h7FFF);
    queue_item(zvrc_pkg::OP_CMD, 4'd4, 1'b0, 15'h0000);
    settle();

    // Directed: all zones, zero pulse time, default list with a skipped entry
    program_valves(4'd15, '0, 1'b1, 4'd4, 64'h0000_0000_0000_F2E1);
    queue_item(zvrc_pkg::OP_RESTORE, 4'd0, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_TICK, 4'd0, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_CMD, 4'd15, 1'b1, 15'h0000);
    queue_item(zvrc_pkg::OP_CMD, 4'd15, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_TICK, 4'd0, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_RESTORE, 4'd0, 1'b0, 15'h7FFF);
    queue_item(zvrc_pkg::OP_TICK, 4'd0, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_CMD, 4'd14, 1'b0, 15'h0000);
    settle();

    // Random phases over a spread of settings
    program_valves(4'd15, zvrc_pkg::PULSE_W'(25), 1'b1, 4'd15, {$urandom, $urandom});
    random_phase(60);
    queue_ticks(30);
    random_phase(10);
    settle();

    program_valves(4'd0, zvrc_pkg::PULSE_W'(3600000), 1'b0, 4'd0, '0);
    random_phase(50);
    settle();

    program_valves(zvrc_pkg::ZONE_IDX_W'($urandom_range(1, 14)),
                   zvrc_pkg::PULSE_W'($urandom_range(0, 40)), 1'($urandom),
                   zvrc_pkg::ZONE_IDX_W'($urandom), {$urandom, $urandom});
    random_phase(80);
    settle();

    program_valves(4'd8, zvrc_pkg::PULSE_W'(1), 1'b1, 4'd3, 64'h0000_0000_0000_0C92);
    random_phase(60);
    settle();

    program_valves(4'd15, PULSE_SAT, 1'b0, 4'd15, '1);
    random_phase(60);
    settle();

    program_valves(zvrc_pkg::ZONE_IDX_W'($urandom), zvrc_pkg::PULSE_W'($urandom_range(1, 60)),
                   1'($urandom), zvrc_pkg::ZONE_IDX_W'($urandom), {$urandom, $urandom});
    random_phase(70);
    settle();

    // Last part, no idling: pulse expiry on a long tick run, then command and restore
    idle_on = 1'b0;
    program_valves(4'd15, zvrc_pkg::PULSE_W'(30), 1'b1, 4'd2, 64'h0000_0000_0000_0073);
    queue_item(zvrc_pkg::OP_CMD, 4'd5, 1'b1, 15'h0000);
    queue_ticks(40);
    queue_item(zvrc_pkg::OP_CMD, 4'd5, 1'b0, 15'h0000);
    queue_item(zvrc_pkg::OP_RESTORE, 4'd0, 1'b0, zvrc_pkg::ZONE_W'($urandom));
    queue_ticks(3);
    settle();

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
